// ===== rtl/assert_macros.svh =====
// Assertion helper macros shared by the RTL modules.
// Each macro expects clk and rst_n in scope; checks are off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication check.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication check.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/das_pkg.sv =====
// Shared types and constants for the drainage accumulation / stream order block.
// No dependencies; imported by das_ctrl, das_dp and the top level.
`default_nettype none
package das_pkg;

  localparam int MAX_CELLS_DEF = 4096;
  localparam int IDX_W         = 12;
  localparam int ACC_W         = 13;
  localparam int ORD_W         = 4;
  localparam int FUNC_W        = 2;
  localparam int CFG_W         = 13;
  localparam int ACC_MAX       = 8191;
  localparam int ORD_MAX       = 15;
  localparam int BKT_DEPTH     = ACC_MAX + 1;
  localparam int BKT_AW        = 13;

  localparam logic [CFG_W-1:0] CELL_COUNT_RST = 13'd4096;
  localparam logic [CFG_W-1:0] RIVER_THR_RST  = 13'd16;

  // Item function codes; code 3 behaves as a load without the write
  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD    = 2'd0,
    FN_COMPUTE = 2'd1,
    FN_READ    = 2'd2
  } das_func_t;

  typedef enum logic [0:0] {
    CFG_CELL_COUNT = 1'b0,
    CFG_RIVER_THR  = 1'b1
  } das_cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RDW, S_RESP,
    S_INIT,
    S_DEG_A, S_DEG_B, S_DEG_C,
    S_SEED_A, S_SEED_B,
    S_KAHN_A, S_KAHN_B, S_KAHN_C, S_KAHN_D,
    S_BCLR,
    S_BCNT_A, S_BCNT_B, S_BCNT_C,
    S_BPRE_A, S_BPRE_B,
    S_BPLACE_A, S_BPLACE_B, S_BPLACE_C,
    S_STR_A, S_STR_B, S_STR_C, S_STR_D,
    S_FIN
  } das_state_t;

  // Controller to datapath
  typedef struct packed {
    das_state_t phase;
    logic       acc_any;
    logic       acc_load;
    logic       acc_read;
    logic       acc_comp;
  } das_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_cell;
    logic last_bkt;
    logic sink;
    logic river;
    logic q_empty;
    logic s_done;
    logic out_free;
  } das_stat_t;

  // Stream order of a river cell from its largest inflow order and tie count
  function automatic logic [ORD_W-1:0] strahler_order(input logic [ORD_W-1:0] mi,
                                                      input logic [1:0]       ct);
    logic [ORD_W-1:0] o;
    if (mi == '0) begin
      o = ORD_W'(1);
    end else if (ct >= 2'd2) begin
      o = (mi == ORD_W'(ORD_MAX)) ? mi : mi + ORD_W'(1);
    end else begin
      o = mi;
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/das_ctrl.sv =====
// Sequencer for the drainage block: input handshake and compute phase stepping.
// Depends on das_pkg; drives das_dp through das_cmd_t, reads das_stat_t back.
`default_nettype none
`include "assert_macros.svh"
module das_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic [das_pkg::FUNC_W-1:0] in_func,
  output logic                            in_stall,
  input  wire das_pkg::das_stat_t         stat,
  output das_pkg::das_cmd_t               cmd
);
  import das_pkg::*;

  das_state_t state_r, state_nxt;
  logic       accept;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_func == FN_COMPUTE)   state_nxt = S_INIT;
          else if (in_func == FN_READ) state_nxt = S_RDW;
          else                         state_nxt = S_RESP;
        end
      end
      S_RDW:      state_nxt = S_RESP;
      S_RESP:     if (stat.out_free) state_nxt = S_IDLE;
      S_INIT:     if (stat.last_cell) state_nxt = S_DEG_A;
      S_DEG_A:    state_nxt = S_DEG_B;
      S_DEG_B: begin
        if (!stat.sink)          state_nxt = S_DEG_C;
        else if (stat.last_cell) state_nxt = S_SEED_A;
        else                     state_nxt = S_DEG_A;
      end
      S_DEG_C:    state_nxt = stat.last_cell ? S_SEED_A : S_DEG_A;
      S_SEED_A:   state_nxt = S_SEED_B;
      S_SEED_B:   state_nxt = stat.last_cell ? S_KAHN_A : S_SEED_A;
      S_KAHN_A:   state_nxt = stat.q_empty ? S_BCLR : S_KAHN_B;
      S_KAHN_B:   state_nxt = S_KAHN_C;
      S_KAHN_C:   state_nxt = stat.sink ? S_KAHN_A : S_KAHN_D;
      S_KAHN_D:   state_nxt = S_KAHN_A;
      S_BCLR:     if (stat.last_bkt) state_nxt = S_BCNT_A;
      S_BCNT_A:   state_nxt = S_BCNT_B;
      S_BCNT_B: begin
        if (stat.river)          state_nxt = S_BCNT_C;
        else if (stat.last_cell) state_nxt = S_BPRE_A;
        else                     state_nxt = S_BCNT_A;
      end
      S_BCNT_C:   state_nxt = stat.last_cell ? S_BPRE_A : S_BCNT_A;
      S_BPRE_A:   state_nxt = S_BPRE_B;
      S_BPRE_B:   state_nxt = stat.last_bkt ? S_BPLACE_A : S_BPRE_A;
      S_BPLACE_A: state_nxt = S_BPLACE_B;
      S_BPLACE_B: begin
        if (stat.river)          state_nxt = S_BPLACE_C;
        else if (stat.last_cell) state_nxt = S_STR_A;
        else                     state_nxt = S_BPLACE_A;
      end
      S_BPLACE_C: state_nxt = stat.last_cell ? S_STR_A : S_BPLACE_A;
      S_STR_A:    state_nxt = stat.s_done ? S_FIN : S_STR_B;
      S_STR_B:    state_nxt = S_STR_C;
      S_STR_C:    state_nxt = stat.sink ? S_STR_A : S_STR_D;
      S_STR_D:    state_nxt = S_STR_A;
      S_FIN:      state_nxt = S_RESP;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd.phase    = state_r;
    cmd.acc_any  = accept;
    cmd.acc_load = accept && (in_func == FN_LOAD);
    cmd.acc_read = accept && (in_func == FN_READ);
    cmd.acc_comp = accept && (in_func == FN_COMPUTE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_NEXT(a_resp_release, state_r == S_RESP && stat.out_free, state_r == S_IDLE, "response not retired")
  `ASSERT_NEXT(a_comp_start, cmd.acc_comp, state_r == S_INIT, "compute did not start")
  `ASSERT_NEXT(a_fin_resp, state_r == S_FIN, state_r == S_RESP, "compute result not posted")

endmodule
`default_nettype wire

// ===== rtl/das_dp.sv =====
// Datapath for the drainage block: cell memories, counters, summary and output register.
// Depends on das_pkg; stepped by das_ctrl through das_cmd_t.
`default_nettype none
`include "assert_macros.svh"
module das_dp #(
  parameter int MAX_CELLS = das_pkg::MAX_CELLS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire das_pkg::das_cmd_t          cmd,
  output das_pkg::das_stat_t              stat,
  input  wire logic [das_pkg::IDX_W-1:0]  in_cell_index,
  input  wire logic [das_pkg::IDX_W-1:0]  in_downstream_index,
  input  wire logic                       cfg_we,
  input  wire logic [0:0]                 cfg_index,
  input  wire logic [das_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire logic                       out_stall,
  output logic                            out_valid,
  output logic [das_pkg::ACC_W-1:0]       out_cell_accum,
  output logic [das_pkg::ORD_W-1:0]       out_cell_order,
  output logic [das_pkg::ACC_W-1:0]       out_released_count,
  output logic                            out_all_released,
  output logic [das_pkg::ACC_W-1:0]       out_max_accum,
  output logic [das_pkg::ORD_W-1:0]       out_max_order
);
  import das_pkg::*;

  localparam int AW = $clog2(MAX_CELLS);
  localparam int CW = $clog2(MAX_CELLS + 1);

  // Memories
  logic [IDX_W-1:0] drain_mem  [MAX_CELLS];
  logic [ACC_W-1:0] accum_mem  [MAX_CELLS];
  logic [CW-1:0]    indeg_mem  [MAX_CELLS];
  logic [AW-1:0]    queue_mem  [MAX_CELLS];
  logic [ORD_W-1:0] order_mem  [MAX_CELLS];
  logic [ORD_W-1:0] maxin_mem  [MAX_CELLS];
  logic [1:0]       cntmx_mem  [MAX_CELLS];
  logic [CW-1:0]    bkt_mem    [BKT_DEPTH];

  logic [IDX_W-1:0] drain_q;
  logic [ACC_W-1:0] accum_q;
  logic [CW-1:0]    indeg_q;
  logic [AW-1:0]    queue_q;
  logic [ORD_W-1:0] order_q;
  logic [ORD_W-1:0] maxin_q;
  logic [1:0]       cntmx_q;
  logic [CW-1:0]    bkt_q;

  logic [AW-1:0]     drain_ra, accum_ra, indeg_ra, queue_ra, order_ra, mx_ra;
  logic [BKT_AW-1:0] bkt_ra;

  logic              drain_we, accum_we, indeg_we, queue_we, order_we, mx_we, bkt_we;
  logic [AW-1:0]     drain_wa, accum_wa, indeg_wa, queue_wa, order_wa, mx_wa;
  logic [BKT_AW-1:0] bkt_wa;
  logic [IDX_W-1:0]  drain_wd;
  logic [ACC_W-1:0]  accum_wd;
  logic [CW-1:0]     indeg_wd, bkt_wd;
  logic [AW-1:0]     queue_wd;
  logic [ORD_W-1:0]  order_wd, maxin_wd;
  logic [1:0]        cntmx_wd;

  // Configuration
  logic [CFG_W-1:0] cell_count_r, river_thr_r;

  // Working registers
  logic [CW-1:0]    c_r, c_nxt, head_r, head_nxt, tail_r, tail_nxt, run_r, run_nxt;
  logic [CW-1:0]    hw_r, hw_nxt;
  logic [AW-1:0]    x_r, x_nxt;
  logic [IDX_W-1:0] d_r, d_nxt, idx_r, idx_nxt;
  logic [ACC_W-1:0] ax_r, ax_nxt, best_acc_r, best_acc_nxt;
  logic [ORD_W-1:0] o_r, o_nxt, best_ord_r, best_ord_nxt;
  logic             rd_item_r, rd_item_nxt;

  // Summary registers
  logic [ACC_W-1:0] sum_rel_r, sum_rel_nxt, sum_macc_r, sum_macc_nxt;
  logic             sum_all_r, sum_all_nxt;
  logic [ORD_W-1:0] sum_mord_r, sum_mord_nxt;

  // Output register
  logic             out_valid_r;
  logic [ACC_W-1:0] out_cell_accum_r, out_released_count_r, out_max_accum_r;
  logic [ORD_W-1:0] out_cell_order_r, out_max_order_r;
  logic             out_all_released_r;

  logic [CW-1:0]    n_w, n_m1_w, top_w, c_adv_w;
  logic [AW-1:0]    sink_ref_w;
  logic [ACC_W:0]   acc_sum_w;
  logic [ACC_W-1:0] acc_sat_w;
  logic [ORD_W-1:0] ord_w;
  logic             load_ok_w, rd_ok_w, in_kahn_w, in_str_w;

  // Cells in use, clamped to the store
  always_comb begin
    if (cell_count_r == '0) begin
      n_w = CW'(1);
    end else if (int'(cell_count_r) > MAX_CELLS) begin
      n_w = CW'(MAX_CELLS);
    end else begin
      n_w = CW'(cell_count_r);
    end
    top_w = (int'(n_w) > ACC_MAX) ? CW'(ACC_MAX) : n_w;
  end

  assign n_m1_w     = n_w - CW'(1);
  assign c_adv_w    = stat.last_cell ? '0 : c_r + CW'(1);
  assign sink_ref_w = (cmd.phase == S_DEG_B) ? c_r[AW-1:0] : x_r;
  assign acc_sum_w  = {1'b0, accum_q} + {1'b0, ax_r};
  assign acc_sat_w  = (int'(acc_sum_w) > ACC_MAX) ? ACC_W'(ACC_MAX) : acc_sum_w[ACC_W-1:0];
  assign ord_w      = strahler_order(maxin_q, cntmx_q);
  assign load_ok_w  = int'(in_cell_index) < MAX_CELLS;
  assign rd_ok_w    = rd_item_r && (int'(idx_r) < int'(n_w)) && (int'(idx_r) < int'(hw_r));
  assign in_kahn_w  = (cmd.phase == S_KAHN_A) || (cmd.phase == S_KAHN_B) ||
                      (cmd.phase == S_KAHN_C) || (cmd.phase == S_KAHN_D);
  assign in_str_w   = (cmd.phase == S_STR_A) || (cmd.phase == S_STR_B) ||
                      (cmd.phase == S_STR_C) || (cmd.phase == S_STR_D);

  // Status
  always_comb begin
    stat.last_cell = (c_r == n_m1_w);
    stat.last_bkt  = (c_r == top_w);
    stat.sink      = (int'(drain_q) == int'(sink_ref_w)) || (int'(drain_q) >= int'(n_w));
    stat.river     = (accum_q > river_thr_r);
    stat.q_empty   = (head_r == tail_r);
    stat.s_done    = (head_r == run_r);
    stat.out_free  = !out_valid_r || !out_stall;
  end

  // Read addresses
  always_comb begin
    drain_ra = c_r[AW-1:0];
    accum_ra = AW'(idx_r);
    order_ra = AW'(idx_r);
    indeg_ra = c_r[AW-1:0];
    queue_ra = head_r[AW-1:0];
    mx_ra    = queue_q;
    bkt_ra   = BKT_AW'(c_r);
    case (cmd.phase)
      S_KAHN_B: begin
        drain_ra = queue_q;
        accum_ra = queue_q;
      end
      S_KAHN_C: begin
        accum_ra = AW'(drain_q);
        indeg_ra = AW'(drain_q);
      end
      S_DEG_B:    indeg_ra = AW'(drain_q);
      S_BCNT_A,
      S_BPLACE_A: accum_ra = c_r[AW-1:0];
      S_BCNT_B,
      S_BPLACE_B: bkt_ra = accum_q;
      S_STR_B:    drain_ra = queue_q;
      S_STR_C: begin
        accum_ra = AW'(drain_q);
        mx_ra    = AW'(drain_q);
      end
      default: begin
      end
    endcase
  end

  // Phase work: memory writes and register updates
  always_comb begin
    drain_we = 1'b0; drain_wa = AW'(in_cell_index); drain_wd = in_downstream_index;
    accum_we = 1'b0; accum_wa = c_r[AW-1:0];        accum_wd = ACC_W'(1);
    indeg_we = 1'b0; indeg_wa = c_r[AW-1:0];        indeg_wd = '0;
    queue_we = 1'b0; queue_wa = tail_r[AW-1:0];     queue_wd = c_r[AW-1:0];
    order_we = 1'b0; order_wa = c_r[AW-1:0];        order_wd = '0;
    mx_we    = 1'b0; mx_wa    = c_r[AW-1:0];        maxin_wd = '0; cntmx_wd = '0;
    bkt_we   = 1'b0; bkt_wa   = BKT_AW'(c_r);       bkt_wd   = '0;

    c_nxt        = c_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    run_nxt      = run_r;
    hw_nxt       = hw_r;
    x_nxt        = x_r;
    d_nxt        = d_r;
    idx_nxt      = idx_r;
    ax_nxt       = ax_r;
    o_nxt        = o_r;
    best_acc_nxt = best_acc_r;
    best_ord_nxt = best_ord_r;
    rd_item_nxt  = rd_item_r;
    sum_rel_nxt  = sum_rel_r;
    sum_all_nxt  = sum_all_r;
    sum_macc_nxt = sum_macc_r;
    sum_mord_nxt = sum_mord_r;

    case (cmd.phase)
      // Take an item
      S_IDLE: begin
        if (cmd.acc_any) begin
          idx_nxt     = in_cell_index;
          rd_item_nxt = cmd.acc_read;
        end
        if (cmd.acc_load && load_ok_w) begin
          drain_we = 1'b1;
        end
        if (cmd.acc_comp) begin
          c_nxt        = '0;
          head_nxt     = '0;
          tail_nxt     = '0;
          best_acc_nxt = '0;
          best_ord_nxt = '0;
        end
      end
      // Reset per-cell working values
      S_INIT: begin
        accum_we = 1'b1;
        indeg_we = 1'b1;
        order_we = 1'b1;
        mx_we    = 1'b1;
        c_nxt    = c_adv_w;
      end
      // Count inflows
      S_DEG_B: begin
        d_nxt = drain_q;
        if (stat.sink) c_nxt = c_adv_w;
      end
      S_DEG_C: begin
        indeg_we = 1'b1;
        indeg_wa = AW'(d_r);
        indeg_wd = indeg_q + CW'(1);
        c_nxt    = c_adv_w;
      end
      // Seed the queue with headwater cells
      S_SEED_B: begin
        if (indeg_q == '0) begin
          queue_we = 1'b1;
          tail_nxt = tail_r + CW'(1);
        end
        c_nxt = c_adv_w;
      end
      // Release cells and push totals downstream
      S_KAHN_A: begin
        if (stat.q_empty) begin
          head_nxt = '0;
          run_nxt  = '0;
        end
      end
      S_KAHN_B: x_nxt = queue_q;
      S_KAHN_C: begin
        d_nxt    = drain_q;
        ax_nxt   = accum_q;
        head_nxt = head_r + CW'(1);
      end
      S_KAHN_D: begin
        accum_we = 1'b1;
        accum_wa = AW'(d_r);
        accum_wd = acc_sat_w;
        indeg_we = 1'b1;
        indeg_wa = AW'(d_r);
        indeg_wd = indeg_q - CW'(1);
        if ((indeg_q == CW'(1)) && (tail_r < n_w)) begin
          queue_we = 1'b1;
          queue_wd = AW'(d_r);
          tail_nxt = tail_r + CW'(1);
        end
      end
      // Clear the accumulation histogram
      S_BCLR: begin
        bkt_we = 1'b1;
        c_nxt  = stat.last_bkt ? '0 : c_r + CW'(1);
      end
      // Count river cells per accumulation, track the largest accumulation
      S_BCNT_B: begin
        ax_nxt = accum_q;
        if (accum_q > best_acc_r) best_acc_nxt = accum_q;
        if (!stat.river) c_nxt = c_adv_w;
      end
      S_BCNT_C: begin
        bkt_we = 1'b1;
        bkt_wa = ax_r;
        bkt_wd = bkt_q + CW'(1);
        c_nxt  = c_adv_w;
      end
      // Turn counts into start positions
      S_BPRE_B: begin
        bkt_we  = 1'b1;
        bkt_wd  = run_r;
        run_nxt = run_r + bkt_q;
        c_nxt   = stat.last_bkt ? '0 : c_r + CW'(1);
      end
      // Place river cells in sorted order
      S_BPLACE_B: begin
        ax_nxt = accum_q;
        if (!stat.river) c_nxt = c_adv_w;
      end
      S_BPLACE_C: begin
        queue_we = 1'b1;
        queue_wa = bkt_q[AW-1:0];
        bkt_we   = 1'b1;
        bkt_wa   = ax_r;
        bkt_wd   = bkt_q + CW'(1);
        c_nxt    = c_adv_w;
      end
      // Assign stream order and forward it downstream
      S_STR_B: x_nxt = queue_q;
      S_STR_C: begin
        order_we = 1'b1;
        order_wa = x_r;
        order_wd = ord_w;
        o_nxt    = ord_w;
        d_nxt    = drain_q;
        head_nxt = head_r + CW'(1);
        if (ord_w > best_ord_r) best_ord_nxt = ord_w;
      end
      S_STR_D: begin
        mx_wa    = AW'(d_r);
        if (stat.river) begin
          if (o_r > maxin_q) begin
            mx_we    = 1'b1;
            maxin_wd = o_r;
            cntmx_wd = 2'd1;
          end else if ((o_r == maxin_q) && (cntmx_q < 2'd2)) begin
            mx_we    = 1'b1;
            maxin_wd = maxin_q;
            cntmx_wd = cntmx_q + 2'd1;
          end
        end
      end
      // Publish the summary
      S_FIN: begin
        sum_rel_nxt  = ACC_W'(tail_r);
        sum_all_nxt  = (tail_r == n_w);
        sum_macc_nxt = best_acc_r;
        sum_mord_nxt = best_ord_r;
        hw_nxt       = (n_w > hw_r) ? n_w : hw_r;
        rd_item_nxt  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Memory ports
  always_ff @(posedge clk) begin
    if (drain_we) drain_mem[drain_wa] <= drain_wd;
    drain_q <= drain_mem[drain_ra];
  end

  always_ff @(posedge clk) begin
    if (accum_we) accum_mem[accum_wa] <= accum_wd;
    accum_q <= accum_mem[accum_ra];
  end

  always_ff @(posedge clk) begin
    if (indeg_we) indeg_mem[indeg_wa] <= indeg_wd;
    indeg_q <= indeg_mem[indeg_ra];
  end

  always_ff @(posedge clk) begin
    if (queue_we) queue_mem[queue_wa] <= queue_wd;
    queue_q <= queue_mem[queue_ra];
  end

  always_ff @(posedge clk) begin
    if (order_we) order_mem[order_wa] <= order_wd;
    order_q <= order_mem[order_ra];
  end

  always_ff @(posedge clk) begin
    if (mx_we) begin
      maxin_mem[mx_wa] <= maxin_wd;
      cntmx_mem[mx_wa] <= cntmx_wd;
    end
    maxin_q <= maxin_mem[mx_ra];
    cntmx_q <= cntmx_mem[mx_ra];
  end

  always_ff @(posedge clk) begin
    if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
    bkt_q <= bkt_mem[bkt_ra];
  end

  // Control and summary registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_count_r <= CELL_COUNT_RST;
      river_thr_r  <= RIVER_THR_RST;
      c_r          <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      run_r        <= '0;
      hw_r         <= '0;
      rd_item_r    <= 1'b0;
      sum_rel_r    <= '0;
      sum_all_r    <= 1'b0;
      sum_macc_r   <= '0;
      sum_mord_r   <= '0;
      best_acc_r   <= '0;
      best_ord_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CELL_COUNT: cell_count_r <= cfg_wdata;
          CFG_RIVER_THR:  river_thr_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end
      c_r        <= c_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      run_r      <= run_nxt;
      hw_r       <= hw_nxt;
      rd_item_r  <= rd_item_nxt;
      sum_rel_r  <= sum_rel_nxt;
      sum_all_r  <= sum_all_nxt;
      sum_macc_r <= sum_macc_nxt;
      sum_mord_r <= sum_mord_nxt;
      best_acc_r <= best_acc_nxt;
      best_ord_r <= best_ord_nxt;
    end
  end

  // Payload working registers
  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    d_r   <= d_nxt;
    idx_r <= idx_nxt;
    ax_r  <= ax_nxt;
    o_r   <= o_nxt;
  end

  // Output register: load when the response phase finds it free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.phase == S_RESP) && stat.out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.phase == S_RESP) && stat.out_free) begin
      out_cell_accum_r     <= rd_ok_w ? accum_q : '0;
      out_cell_order_r     <= rd_ok_w ? order_q : '0;
      out_released_count_r <= sum_rel_r;
      out_all_released_r   <= sum_all_r;
      out_max_accum_r      <= sum_macc_r;
      out_max_order_r      <= sum_mord_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cell_accum     = out_cell_accum_r;
  assign out_cell_order     = out_cell_order_r;
  assign out_released_count = out_released_count_r;
  assign out_all_released   = out_all_released_r;
  assign out_max_accum      = out_max_accum_r;
  assign out_max_order      = out_max_order_r;

  `ASSERT_IMPL(a_tail_bound, in_kahn_w, tail_r <= n_w, "release queue beyond cells in use")
  `ASSERT_IMPL(a_head_tail, in_kahn_w, head_r <= tail_r, "queue head passed tail")
  `ASSERT_IMPL(a_str_head, in_str_w, head_r <= run_r, "order walk passed river count")

endmodule
`default_nettype wire

// ===== rtl/drainage_accumulation_strahler.sv =====
// Drainage accumulation and stream order block.
// Channels: input items (in_valid/in_stall; func, cell_index, downstream_index) and
// result items (out_valid/out_stall), one result per accepted item, in order.
// Configuration: cfg_we/cfg_index/cfg_wdata writes cell_count (0) or river_threshold (1);
// the user must write only while the block is idle, which the block does not enforce.
// A load goes straight to the response state; a read passes a read-wait state first.
// A compute walks every cell several times through memories with one read and one
// write port each, in order: init, inflow count, seed, release of each cell with its
// total pushed downstream, histogram clear over buckets 0 to min(n,8191), histogram
// count of river cells, prefix scan over the same buckets, placement of river cells,
// stream order per river cell, then publish and post; n the cells in use.
// Throughput: one item at a time; the next item is taken once the previous one has
// reached the output register, so a result may wait there while the next item runs.
// Reset: cell_count 4096, river_threshold 16, summary zero. Accumulation and order
// stores read as zero above the high-water mark of computed cells, so no clearing
// pass follows reset. A stalled result holds in the output register; the block
// stalls input only while an item is in progress or its result cannot be posted.
`default_nettype none
module drainage_accumulation_strahler #(
  parameter int MAX_CELLS = das_pkg::MAX_CELLS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [0:0]                 cfg_index,
  input  wire logic [das_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [das_pkg::FUNC_W-1:0] in_func,
  input  wire logic [das_pkg::IDX_W-1:0]  in_cell_index,
  input  wire logic [das_pkg::IDX_W-1:0]  in_downstream_index,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [das_pkg::ACC_W-1:0]       out_cell_accum,
  output logic [das_pkg::ORD_W-1:0]       out_cell_order,
  output logic [das_pkg::ACC_W-1:0]       out_released_count,
  output logic                            out_all_released,
  output logic [das_pkg::ACC_W-1:0]       out_max_accum,
  output logic [das_pkg::ORD_W-1:0]       out_max_order
);
  import das_pkg::*;

  das_cmd_t  cmd;
  das_stat_t stat;

  // Sequencer
  das_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Memories and arithmetic
  das_dp #(
    .MAX_CELLS (MAX_CELLS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_cell_index       (in_cell_index),
    .in_downstream_index (in_downstream_index),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_cell_accum      (out_cell_accum),
    .out_cell_order      (out_cell_order),
    .out_released_count  (out_released_count),
    .out_all_released    (out_all_released),
    .out_max_accum       (out_max_accum),
    .out_max_order       (out_max_order)
  );

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for drainage_accumulation_strahler: directed table, then random
// drainage forests, checked against a behavioral flow/stream-order predictor.
// Depends on das_pkg and the drainage_accumulation_strahler RTL.
`default_nettype none
module testbench;
  import das_pkg::*;

  localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;
  localparam int NCELL = MAX_CELLS_DEF;

  typedef struct {
    logic [ACC_W-1:0] accum;
    logic [ORD_W-1:0] order;
    logic [ACC_W-1:0] released;
    logic             all_rel;
    logic [ACC_W-1:0] max_acc;
    logic [ORD_W-1:0] max_ord;
  } flow_result_t;

  // Directed row: either a configuration write or a transaction
  typedef struct {
    bit               is_cfg;
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0] cell_idx;
    logic [IDX_W-1:0] dst;
    bit               typed;
  } flow_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = CFG_CELL_COUNT;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [FUNC_W-1:0] in_func = FN_LOAD;
  logic [IDX_W-1:0] in_cell_index = '0;
  logic [IDX_W-1:0] in_downstream_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ACC_W-1:0] out_cell_accum;
  logic [ORD_W-1:0] out_cell_order;
  logic [ACC_W-1:0] out_released_count;
  logic out_all_released;
  logic [ACC_W-1:0] out_max_accum;
  logic [ORD_W-1:0] out_max_order;

  drainage_accumulation_strahler u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_cell_index(in_cell_index), .in_downstream_index(in_downstream_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_cell_accum(out_cell_accum), .out_cell_order(out_cell_order),
    .out_released_count(out_released_count), .out_all_released(out_all_released),
    .out_max_accum(out_max_accum), .out_max_order(out_max_order)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state
  logic [CFG_W-1:0] cell_count_reg = CELL_COUNT_RST;
  logic [CFG_W-1:0] river_thr_reg = RIVER_THR_RST;
  logic [IDX_W-1:0] drain_tab [NCELL];
  bit               drain_loaded [NCELL];
  int               acc_tab [NCELL];
  int               deg_tab [NCELL];
  int               ord_tab [NCELL];
  int               inflow_max [NCELL];
  int               inflow_cnt [NCELL];
  int               release_q [NCELL];
  int               bucket [ACC_MAX + 2];
  int               by_accum [NCELL];
  int               sum_released, sum_all, sum_max_acc, sum_max_ord;

  flow_result_t expected_q [$];
  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int computes = 0;

  function automatic int cells_used();
    int n;
    n = cell_count_reg;
    if (n == 0) n = 1;
    if (n > NCELL) n = NCELL;
    return n;
  endfunction

  // Kahn release pass, then stream order in ascending accumulation order
  task automatic flow_compute();
    int n, head, tail, run, t, x, d, o;
    n = cells_used();
    for (int c = 0; c < n; c++) begin
      acc_tab[c] = 1; deg_tab[c] = 0; ord_tab[c] = 0;
      inflow_max[c] = 0; inflow_cnt[c] = 0;
    end
    for (int c = 0; c < n; c++) begin
      d = drain_tab[c];
      if (d != c && d < n) deg_tab[d]++;
    end
    tail = 0;
    for (int c = 0; c < n; c++)
      if (deg_tab[c] == 0) begin
        release_q[tail] = c;
        tail++;
      end
    for (head = 0; head < tail; head++) begin
      x = release_q[head];
      d = drain_tab[x];
      if (d != x && d < n) begin
        acc_tab[d] = (acc_tab[d] + acc_tab[x] > ACC_MAX) ? ACC_MAX : acc_tab[d] + acc_tab[x];
        deg_tab[d]--;
        if (deg_tab[d] == 0 && tail < n) begin
          release_q[tail] = d;
          tail++;
        end
      end
    end
    // stable counting sort by accumulation
    for (int i = 0; i <= ACC_MAX + 1; i++) bucket[i] = 0;
    for (int c = 0; c < n; c++) bucket[acc_tab[c]]++;
    run = 0;
    for (int i = 0; i <= ACC_MAX + 1; i++) begin
      t = bucket[i];
      bucket[i] = run;
      run += t;
    end
    for (int c = 0; c < n; c++) begin
      by_accum[bucket[acc_tab[c]]] = c;
      bucket[acc_tab[c]]++;
    end
    for (int i = 0; i < n; i++) begin
      x = by_accum[i];
      if (acc_tab[x] > river_thr_reg) begin
        if (inflow_max[x] == 0) o = 1;
        else if (inflow_cnt[x] >= 2) o = (inflow_max[x] + 1 > ORD_MAX) ? ORD_MAX : inflow_max[x] + 1;
        else o = inflow_max[x];
        ord_tab[x] = o;
        d = drain_tab[x];
        if (d != x && d < n && acc_tab[d] > river_thr_reg) begin
          if (o > inflow_max[d]) begin
            inflow_max[d] = o;
            inflow_cnt[d] = 1;
          end else if (o == inflow_max[d] && inflow_cnt[d] < 2) begin
            inflow_cnt[d]++;
          end
        end
      end
    end
    sum_max_acc = 0;
    sum_max_ord = 0;
    for (int c = 0; c < n; c++) begin
      if (acc_tab[c] > sum_max_acc) sum_max_acc = acc_tab[c];
      if (ord_tab[c] > sum_max_ord) sum_max_ord = ord_tab[c];
    end
    sum_released = tail;
    sum_all = (tail == n);
  endtask

  // Update the predictor for one accepted transaction and return its result
  task automatic flow_predict(input logic [FUNC_W-1:0] f, input int cell_idx, input int dst,
                              output flow_result_t r);
    r.accum = '0;
    r.order = '0;
    case (f)
      FN_LOAD: begin
        drain_tab[cell_idx] = IDX_W'(dst);
        drain_loaded[cell_idx] = 1'b1;
      end
      FN_COMPUTE: begin
        flow_compute();
        computes++;
      end
      FN_READ: begin
        if (cell_idx < cells_used()) begin
          r.accum = ACC_W'(acc_tab[cell_idx]);
          r.order = ORD_W'(ord_tab[cell_idx]);
        end
      end
      default: ;
    endcase
    r.released = ACC_W'(sum_released);
    r.all_rel = (sum_all != 0);
    r.max_acc = ACC_W'(sum_max_acc);
    r.max_ord = ORD_W'(sum_max_ord);
  endtask

  // Offer one transaction; hold it until accepted, then record the expectation
  task automatic send_item(input logic [FUNC_W-1:0] f, input int cell_idx, input int dst,
                           input bit typed);
    flow_result_t r;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_cell_index <= IDX_W'(cell_idx);
    in_downstream_index <= IDX_W'(dst);
    do @(posedge clk); while (in_stall);
    flow_predict(f, cell_idx, dst, r);
    // typed rows right after reset expect all zero
    if (typed) r = '{default: '0};
    expected_q = {expected_q, r};
    items_sent++;
  endtask

  // Wait for the block to drain, then write one register
  task automatic write_cfg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CELL_COUNT) cell_count_reg = val;
    else river_thr_reg = val;
  endtask

  // Load any unloaded cell in use, then compute
  task automatic safe_compute();
    for (int c = 0; c < cells_used(); c++)
      if (!drain_loaded[c]) send_item(FN_LOAD, c, c, 1'b0);
    send_item(FN_COMPUTE, $urandom_range(4095), $urandom_range(4095), 1'b0);
  endtask

  // One random phase: mostly a well-formed forest, with noise and cycles
  task automatic forest_phase(input int cnt, input int thr);
    int n, dst, k;
    write_cfg(CFG_CELL_COUNT, CFG_W'(cnt));
    write_cfg(CFG_RIVER_THR, CFG_W'(thr));
    n = cells_used();
    for (int c = 0; c < n; c++) begin
      if ($urandom_range(9) == 0) dst = $urandom_range(4095);
      else begin
        case ($urandom_range(3))
          0: dst = c;
          1: dst = (n < NCELL) ? $urandom_range(4095, n) : c;
          default: dst = (c < n - 1) ? $urandom_range(n - 1, c + 1) : c;
        endcase
      end
      send_item(FN_LOAD, c, dst, 1'b0);
      if ($urandom_range(15) == 0)
        send_item($urandom_range(1) ? FN_READ : FN_SPARE, $urandom_range(4095),
                  $urandom_range(4095), 1'b0);
    end
    safe_compute();
    k = $urandom_range(8, 3);
    for (int i = 0; i < k; i++)
      send_item(FN_READ, ($urandom_range(7) == 0) ? $urandom_range(4095)
                : $urandom_range(n + 1), $urandom_range(4095), 1'b0);
    if ($urandom_range(3) == 0) begin
      send_item(FN_LOAD, $urandom_range(n - 1), $urandom_range(4095), 1'b0);
      safe_compute();
      send_item(FN_READ, $urandom_range(n - 1), 0, 1'b0);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    flow_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result accum=%0d", $time, out_cell_accum);
      end else begin
        e = expected_q.pop_front();
        if (out_cell_accum !== e.accum || out_cell_order !== e.order ||
            out_released_count !== e.released || out_all_released !== e.all_rel ||
            out_max_accum !== e.max_acc || out_max_order !== e.max_ord) begin
          errors++;
          $display("%0t: mismatch expected %0d/%0d/%0d/%0d/%0d/%0d",
                   $time, e.accum, e.order, e.released, e.all_rel, e.max_acc, e.max_ord);
          $display("%0t:          got %0d/%0d/%0d/%0d/%0d/%0d",
                   $time, out_cell_accum, out_cell_order, out_released_count,
                   out_all_released, out_max_accum, out_max_order);
        end
      end
    end
  end

  // Receiver stall
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // Hard limit on run time
  initial begin
    #200000000;
    $display("drainage_accumulation_strahler regression: fail");
    $finish;
  end

  flow_row_t dir_rows [25];

  initial begin
    int mode, guard;
    for (int c = 0; c < NCELL; c++) begin
      drain_tab[c] = '0; drain_loaded[c] = 1'b0;
      acc_tab[c] = 0; ord_tab[c] = 0;
    end
    sum_released = 0; sum_all = 0; sum_max_acc = 0; sum_max_ord = 0;

    dir_rows = '{
      '{0, FN_READ, 0, 0, 1}, '{0, FN_READ, 4095, 4095, 1}, '{0, FN_SPARE, 4095, 4095, 1},
      '{0, FN_LOAD, 4095, 4095, 1}, '{0, FN_LOAD, 0, 0, 1},
      '{1, FN_LOAD, CFG_CELL_COUNT, 4, 0}, '{1, FN_LOAD, CFG_RIVER_THR, 0, 0},
      '{0, FN_LOAD, 0, 1, 0}, '{0, FN_LOAD, 1, 3, 0}, '{0, FN_LOAD, 2, 3, 0},
      '{0, FN_LOAD, 3, 3, 0}, '{0, FN_COMPUTE, 0, 0, 0},
      '{0, FN_READ, 0, 0, 0}, '{0, FN_READ, 1, 0, 0}, '{0, FN_READ, 3, 0, 0},
      '{0, FN_READ, 4, 0, 0}, '{0, FN_LOAD, 3, 4095, 0}, '{0, FN_LOAD, 1, 0, 0},
      '{0, FN_COMPUTE, 0, 0, 0}, '{0, FN_READ, 0, 0, 0}, '{0, FN_READ, 3, 0, 0},
      '{1, FN_LOAD, CFG_CELL_COUNT, 0, 0}, '{0, FN_COMPUTE, 0, 0, 0},
      '{0, FN_READ, 0, 0, 0}, '{0, FN_READ, 1, 0, 0}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_cfg(dir_rows[i].cell_idx[0], CFG_W'(dir_rows[i].dst));
      else send_item(dir_rows[i].func, dir_rows[i].cell_idx, dir_rows[i].dst,
                     dir_rows[i].typed);
    end

    // Larger forests, one with the threshold at 4096, then the clamped cell count
    forest_phase(160, 4096);
    forest_phase($urandom_range(120, 60), $urandom_range(64));
    write_cfg(CFG_CELL_COUNT, CFG_W'(8191));
    send_item(FN_READ, 4095, 0, 1'b0);
    send_item(FN_READ, 0, 0, 1'b0);

    // Small random forests under rotating idle and receiver stall patterns
    mode = 0;
    while (items_sent < 1250) begin
      case (mode % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 72; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 72; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      case ($urandom_range(5))
        0: forest_phase($urandom_range(3), $urandom_range(2));
        1: forest_phase($urandom_range(48, 1), 0);
        default: forest_phase($urandom_range(40, 1), $urandom_range(6));
      endcase
      mode++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);
    $display("Sent %0d transactions (%0d computes), checked %0d results.",
             items_sent, computes, results_seen);
    if (errors == 0 && expected_q.size() == 0)
      $display("drainage_accumulation_strahler regression: pass");
    else
      $display("drainage_accumulation_strahler regression: fail");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/das_pkg.sv
rtl/das_ctrl.sv
rtl/das_dp.sv
rtl/drainage_accumulation_strahler.sv
bench/testbench.sv
